// ===== sv/fpa_pkg.sv =====
// shared types and constants of the fixed-point alu
`timescale 1ns / 1ps
`default_nettype none
package fpa_pkg;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int QCNT_W = 3;

    typedef enum logic [3:0] {
        OP_ADD        = 4'd0,
        OP_SUB        = 4'd1,
        OP_MUL        = 4'd2,
        OP_DIV        = 4'd3,
        OP_CMP        = 4'd4,
        OP_MIN        = 4'd5,
        OP_MAX        = 4'd6,
        OP_INC        = 4'd7,
        OP_DEC        = 4'd8,
        OP_FROM_INT   = 4'd9,
        OP_FROM_FLOAT = 4'd10,
        OP_TO_INT     = 4'd11,
        OP_TO_FLOAT   = 4'd12
    } t_op;

    typedef enum logic [1:0] {
        FK_NORM  = 2'd0,
        FK_ZERO  = 2'd1,
        FK_LIMIT = 2'd2,
        FK_NAN   = 2'd3
    } t_fkind;

    // item as classified by the front end
    typedef struct packed {
        t_op         op;
        logic [31:0] a;
        logic [31:0] mag_a;
        logic [31:0] mag_b;
        logic        neg;
        logic        lt;
        logic        gt;
        logic        eq;
        logic        dz;
        logic [31:0] res;
    } t_qitem;

    // per-stage information in the back end
    typedef struct packed {
        t_op         op;
        logic        neg;
        logic        lt;
        logic        gt;
        logic        eq;
        logic        dz;
        logic        sat;
        logic [31:0] res;
    } t_info;

endpackage
`default_nettype wire

// ===== sv/fpa_req_if.sv =====
// request channel of the fixed-point alu
`timescale 1ns / 1ps
`default_nettype none
interface fpa_req_if;
    logic               valid;
    logic               ready;
    logic [3:0]         cmd;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;

    modport source (output valid, cmd, operand_a, operand_b, input ready);
    modport sink (input valid, cmd, operand_a, operand_b, output ready);
endinterface
`default_nettype wire

// ===== sv/fpa_rsp_if.sv =====
// response channel of the fixed-point alu
`timescale 1ns / 1ps
`default_nettype none
interface fpa_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] result_bits;
    logic        less;
    logic        greater;
    logic        equal;
    logic        divide_by_zero;
    logic        saturated;

    modport source (output valid, result_bits, less, greater, equal, divide_by_zero,
                    saturated, input ready);
    modport sink (input valid, result_bits, less, greater, equal, divide_by_zero,
                  saturated, output ready);
endinterface
`default_nettype wire

// ===== sv/fixed_point_q24_8_alu.sv =====
// top level of the signed 32-bit fixed-point alu
// usage:
//   i_req carries cmd, operand_a and operand_b; a transfer happens on a rising
//   edge with valid and ready high. o_rsp returns one result per request, in
//   order, with the 32-bit result pattern and the compare and error flags.
// pipeline and throughput:
//   a request transferred on i_req passes the queue, then 32 + FRAC_BITS + 1
//   back-end stages (FRAC_BITS = 8 for the default Q24.8) before it is
//   presented on o_rsp; the stage count is set by the divider, which
//   resolves one quotient bit per pipeline stage.
//   one request per cycle unless o_rsp stalls; every op takes the same path
// stalls:
//   when o_rsp is held off the whole back-end pipeline freezes; the four-entry
//   queue behind the front end keeps taking requests until it fills, then
//   i_req.ready drops
// reset:
//   synchronous, active low; clears the queue and all stage valid bits, no
//   result is presented until new requests arrive
`timescale 1ns / 1ps
`default_nettype none
module fixed_point_q24_8_alu #(
    parameter int FRAC_BITS = 8
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    fpa_req_if.sink   i_req,
    fpa_rsp_if.source o_rsp
);

    // front end to queue
    logic            push;
    logic            q_full;
    fpa_pkg::t_qitem push_item;

    // queue to back end
    logic            q_valid;
    logic            pop;
    fpa_pkg::t_qitem head_item;

    // compare flags, mags and the combinational operations
    fpa_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .i_req  (i_req),
        .i_full (q_full),
        .o_push (push),
        .o_item (push_item)
    );

    // decouples acceptance from back-end stalls
    fpa_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_item  (head_item),
        .i_pop   (pop)
    );

    // multiplier, divider pipeline, float conversions
    fpa_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_item  (head_item),
        .o_pop   (pop),
        .o_rsp   (o_rsp)
    );

endmodule
`default_nettype wire

// ===== sv/fpa_front.sv =====
// front end: accepts requests, compares operands, does the combinational operations
`timescale 1ns / 1ps
`default_nettype none
module fpa_front #(
    parameter int FRAC_BITS = 8
) (
    fpa_req_if.sink        i_req,
    input  logic           i_full,
    output logic           o_push,
    output fpa_pkg::t_qitem o_item
);

    logic [31:0]  a;
    logic [31:0]  b;
    fpa_pkg::t_op op;
    logic         lt;
    logic         gt;

    assign a  = i_req.operand_a;
    assign b  = i_req.operand_b;
    assign op = fpa_pkg::t_op'(i_req.cmd);
    assign lt = $signed(a) < $signed(b);
    assign gt = $signed(a) > $signed(b);

    assign i_req.ready = !i_full;
    assign o_push      = i_req.valid && !i_full;

    always_comb begin
        o_item       = '0;
        o_item.op    = op;
        o_item.a     = a;
        o_item.mag_a = a[31] ? (~a + 32'd1) : a;
        o_item.mag_b = b[31] ? (~b + 32'd1) : b;
        o_item.neg   = a[31] ^ b[31];
        o_item.lt    = lt;
        o_item.gt    = gt;
        o_item.eq    = (a == b);
        o_item.dz    = (op == fpa_pkg::OP_DIV) && (b == 32'd0);
        case (op)
            fpa_pkg::OP_ADD:      o_item.res = a + b;
            fpa_pkg::OP_SUB:      o_item.res = a - b;
            fpa_pkg::OP_CMP:      o_item.res = lt ? 32'hFFFF_FFFF : (gt ? 32'd1 : 32'd0);
            fpa_pkg::OP_MIN:      o_item.res = lt ? a : b;
            fpa_pkg::OP_MAX:      o_item.res = gt ? a : b;
            fpa_pkg::OP_INC:      o_item.res = a + 32'd1;
            fpa_pkg::OP_DEC:      o_item.res = a - 32'd1;
            fpa_pkg::OP_FROM_INT: o_item.res = a << FRAC_BITS;
            fpa_pkg::OP_TO_INT:   o_item.res = 32'($signed(a) >>> FRAC_BITS);
            default:              o_item.res = 32'd0;
        endcase
    end

endmodule
`default_nettype wire

// ===== sv/fpa_queue.sv =====
// short queue between front and back end
`timescale 1ns / 1ps
`default_nettype none
module fpa_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  fpa_pkg::t_qitem i_item,
    output logic            o_full,
    output logic            o_valid,
    output fpa_pkg::t_qitem o_item,
    input  logic            i_pop
);

    fpa_pkg::t_qitem               r_mem [fpa_pkg::QDEPTH];
    logic [fpa_pkg::QPTR_W-1:0]    r_wp;
    logic [fpa_pkg::QPTR_W-1:0]    r_rp;
    logic [fpa_pkg::QCNT_W-1:0]    r_cnt;
    logic [fpa_pkg::QCNT_W-1:0]    n_cnt;

    assign o_full  = (r_cnt == fpa_pkg::QCNT_W'(fpa_pkg::QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_mem[r_rp];

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full && !i_pop))
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && !o_valid))
        else $error("pop from empty queue");

    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_cnt == $past(r_cnt) + 1'b1))
        else $error("queue count lost a push");

endmodule
`default_nettype wire

// ===== sv/fpa_back.sv =====
// back end: multiply, pipelined divide, float conversions, output register
`timescale 1ns / 1ps
`default_nettype none
module fpa_back #(
    parameter int FRAC_BITS = 8
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  fpa_pkg::t_qitem i_item,
    output logic            o_pop,
    fpa_rsp_if.source       o_rsp
);

    localparam int NW   = 32 + FRAC_BITS;
    localparam int LAST = NW + 1;

    // one restoring divide step: {remainder, shifted word with quotient bit}
    function automatic logic [32+NW-1:0] div_step(input logic [31:0] rem,
                                                  input logic [NW-1:0] w,
                                                  input logic [31:0] d);
        logic [32:0] sh;
        logic        ge;
        logic [32:0] diff;
        sh   = {rem, w[NW-1]};
        ge   = (sh >= {1'b0, d});
        diff = sh - {1'b0, d};
        return {(ge ? diff[31:0] : sh[31:0]), w[NW-2:0], ge};
    endfunction

    logic                 en;
    logic [1:LAST]        r_vld;
    fpa_pkg::t_info       r_info [1:LAST];
    logic [31:0]          r_rem  [1:NW];
    logic [NW-1:0]        r_wrd  [1:NW];
    logic [31:0]          r_dvs  [1:NW];

    // stage 1 side registers
    logic [63:0]          r_prod;
    logic [63:0]          r_fmag;
    fpa_pkg::t_fkind      r_fkind;
    logic                 r_fsign;
    logic [4:0]           r_p;
    logic [31:0]          r_mag;

    assign en    = !r_vld[LAST] || o_rsp.ready;
    assign o_pop = en && i_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {i_valid, r_vld[1:LAST-1]};
        end
    end

    // stage 1: product, float parse, leading one, first divide step
    logic [7:0]          expf;
    logic [22:0]         man;
    logic [23:0]         sig;
    logic [7:0]          eb;
    logic signed [10:0]  e;
    logic [10:0]         s;
    logic [63:0]         n_fmag;
    fpa_pkg::t_fkind     n_fkind;
    logic [4:0]          n_p;
    logic [32+NW-1:0]    first_step;
    fpa_pkg::t_info      n_info1;

    always_comb begin
        expf    = i_item.a[30:23];
        man     = i_item.a[22:0];
        sig     = (expf == 8'd0) ? {1'b0, man} : {1'b1, man};
        eb      = (expf == 8'd0) ? 8'd1 : expf;
        e       = $signed({3'b000, eb}) + $signed(11'(FRAC_BITS)) - 11'sd150;
        s       = 11'(-e);
        n_fmag  = '0;
        n_fkind = fpa_pkg::FK_NORM;
        if (expf == 8'hFF) begin
            n_fkind = (man != 23'd0) ? fpa_pkg::FK_NAN : fpa_pkg::FK_LIMIT;
        end else if (sig == 24'd0) begin
            n_fkind = fpa_pkg::FK_ZERO;
        end else if (e >= 0) begin
            if (e > 11'sd40) begin
                n_fkind = fpa_pkg::FK_LIMIT;
            end else begin
                n_fmag = 64'(sig) << e[5:0];
            end
        end else if (s >= 11'd26) begin
            n_fkind = fpa_pkg::FK_ZERO;
        end else begin
            n_fmag = 64'(sig >> s[4:0]) + 64'((sig >> (s[4:0] - 5'd1)) & 24'd1);
        end
    end

    always_comb begin
        n_p = '0;
        for (int i = 0; i < 32; i++) begin
            if (i_item.mag_a[i]) n_p = 5'(i);
        end
    end

    assign first_step = div_step(32'd0, {i_item.mag_a, FRAC_BITS'(0)}, i_item.mag_b);

    always_comb begin
        n_info1     = '0;
        n_info1.op  = i_item.op;
        n_info1.neg = i_item.neg;
        n_info1.lt  = i_item.lt;
        n_info1.gt  = i_item.gt;
        n_info1.eq  = i_item.eq;
        n_info1.dz  = i_item.dz;
        n_info1.sat = 1'b0;
        n_info1.res = i_item.res;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_prod               <= 64'(i_item.mag_a) * 64'(i_item.mag_b);
            r_fmag               <= n_fmag;
            r_fkind              <= n_fkind;
            r_fsign              <= i_item.a[31];
            r_p                  <= n_p;
            r_mag                <= i_item.mag_a;
            r_info[1]            <= n_info1;
            {r_rem[1], r_wrd[1]} <= first_step;
            r_dvs[1]             <= i_item.mag_b;
        end
    end

    // stage 2: finish multiply and float conversions
    fpa_pkg::t_info n_info2;
    logic [63:0]    prod_sh;
    logic [63:0]    limit;
    logic [31:0]    tf_t;
    logic [4:0]     tf_sh;
    logic [31:0]    tf_rem;
    logic [31:0]    tf_half;
    logic [24:0]    tf_sig;
    logic [5:0]     tf_pe;
    logic [7:0]     tf_exp;

    always_comb begin
        n_info2 = r_info[1];
        prod_sh = r_prod >> FRAC_BITS;
        limit   = r_fsign ? 64'h8000_0000 : 64'h7FFF_FFFF;
        tf_t    = '0;
        tf_sh   = '0;
        tf_rem  = '0;
        tf_half = '0;
        tf_sig  = '0;
        tf_pe   = {1'b0, r_p};
        if (r_p <= 5'd23) begin
            tf_t   = r_mag << (5'd23 - r_p);
            tf_sig = {1'b0, tf_t[23:0]};
        end else begin
            tf_sh   = r_p - 5'd23;
            tf_t    = r_mag >> tf_sh;
            tf_rem  = r_mag & ((32'd1 << tf_sh) - 32'd1);
            tf_half = 32'd1 << (tf_sh - 5'd1);
            tf_sig  = {1'b0, tf_t[23:0]};
            if (tf_rem > tf_half || (tf_rem == tf_half && tf_t[0])) begin
                tf_sig = tf_sig + 25'd1;
            end
            if (tf_sig[24]) begin
                tf_sig = tf_sig >> 1;
                tf_pe  = tf_pe + 6'd1;
            end
        end
        tf_exp = 8'(32'(tf_pe) + 32'd127 - 32'(FRAC_BITS));
        case (r_info[1].op)
            fpa_pkg::OP_MUL: begin
                n_info2.res = r_info[1].neg ? (~prod_sh[31:0] + 32'd1) : prod_sh[31:0];
            end
            fpa_pkg::OP_FROM_FLOAT: begin
                case (r_fkind)
                    fpa_pkg::FK_ZERO: begin
                        n_info2.res = 32'd0;
                    end
                    fpa_pkg::FK_NAN: begin
                        n_info2.res = 32'd0;
                        n_info2.sat = 1'b1;
                    end
                    fpa_pkg::FK_LIMIT: begin
                        n_info2.res = limit[31:0];
                        n_info2.sat = 1'b1;
                    end
                    default: begin
                        if (r_fmag > limit) begin
                            n_info2.res = limit[31:0];
                            n_info2.sat = 1'b1;
                        end else begin
                            n_info2.res = r_fsign ? (~r_fmag[31:0] + 32'd1) : r_fmag[31:0];
                        end
                    end
                endcase
            end
            fpa_pkg::OP_TO_FLOAT: begin
                if (r_mag == 32'd0) begin
                    n_info2.res = 32'd0;
                end else begin
                    n_info2.res = {r_fsign, tf_exp, tf_sig[22:0]};
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_info[2] <= n_info2;
        end
    end

    // divide steps, one quotient bit per stage
    for (genvar k = 2; k <= NW; k++) begin : g_div
        always_ff @(posedge i_clk) begin
            if (en) begin
                {r_rem[k], r_wrd[k]} <= div_step(r_rem[k-1], r_wrd[k-1], r_dvs[k-1]);
                r_dvs[k]             <= r_dvs[k-1];
            end
        end
    end

    for (genvar k = 3; k <= NW; k++) begin : g_info
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_info[k] <= r_info[k-1];
            end
        end
    end

    // output stage: sign the quotient, or zero it on divide by zero
    fpa_pkg::t_info n_infol;
    logic [31:0]    quo;

    always_comb begin
        n_infol = r_info[NW];
        quo     = r_wrd[NW][31:0];
        if (r_info[NW].op == fpa_pkg::OP_DIV) begin
            if (r_info[NW].dz) begin
                n_infol.res = 32'd0;
            end else begin
                n_infol.res = r_info[NW].neg ? (~quo + 32'd1) : quo;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_info[LAST] <= n_infol;
        end
    end

    assign o_rsp.valid          = r_vld[LAST];
    assign o_rsp.result_bits    = r_info[LAST].res;
    assign o_rsp.less           = r_info[LAST].lt;
    assign o_rsp.greater        = r_info[LAST].gt;
    assign o_rsp.equal          = r_info[LAST].eq;
    assign o_rsp.divide_by_zero = r_info[LAST].dz;
    assign o_rsp.saturated      = r_info[LAST].sat;

endmodule
`default_nettype wire
